// ===== hw/rtl/wse_pkg.sv =====
// Shared types, constants and the nibble encoder for the WS2812 SPI frame encoder.
// No dependencies; every other file in hw/rtl refers to it by scoped names.
package wse_pkg;

  localparam int COLOR_W   = 8;
  localparam int LED_CNT_W = 11;
  localparam int TRAIL_W   = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 11;
  localparam int BYTE_IDX_W = 4;

  // Item commands
  localparam logic CMD_SET   = 1'b0;
  localparam logic CMD_FETCH = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LED_COUNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TRAILER    = 2'd2;

  // Register reset values
  localparam logic [COLOR_W-1:0]   BRIGHTNESS_RST = 8'd80;
  localparam logic [LED_CNT_W-1:0] LED_COUNT_RST  = 11'd1;
  localparam logic [TRAIL_W-1:0]   TRAILER_RST    = 8'd48;

  // Last SPI byte index within one LED (3 colors x 4 bytes)
  localparam logic [BYTE_IDX_W-1:0] LAST_BYTE_IDX = 4'd11;

  // One LED bit becomes one nibble on the wire
  localparam logic [3:0] NIB_ONE  = 4'hE;
  localparam logic [3:0] NIB_ZERO = 4'h8;

  typedef struct packed {
    logic arm;    // set color accepted: latch colors, restart frame
    logic fetch;  // fetch accepted: emit next byte if a frame is armed
  } seq_ctrl_t;

  typedef struct packed {
    logic [LED_CNT_W-1:0] chain_len;
    logic [TRAIL_W-1:0]   trailer_bytes;
  } frame_cfg_t;

  // Two LED bits of a color byte, MSB first, as one SPI byte
  function automatic logic [7:0] encode_pair(input logic [COLOR_W-1:0] color,
                                             input logic [1:0] sub);
    logic [1:0] pair;
    pair = 2'b00;
    case (sub)
      2'd0:    pair = color[7:6];
      2'd1:    pair = color[5:4];
      2'd2:    pair = color[3:2];
      default: pair = color[1:0];
    endcase
    return {(pair[1] ? NIB_ONE : NIB_ZERO), (pair[0] ? NIB_ONE : NIB_ZERO)};
  endfunction

endpackage

// ===== hw/rtl/wse_color_scale.sv =====
// Scales one 8-bit color by brightness: value*brightness/255, truncated.
// Depends on wse_pkg for widths.
module wse_color_scale (
  input  logic [wse_pkg::COLOR_W-1:0] value,
  input  logic [wse_pkg::COLOR_W-1:0] brightness,
  output logic [wse_pkg::COLOR_W-1:0] scaled
);

  logic [2*wse_pkg::COLOR_W-1:0] product;
  logic [2*wse_pkg::COLOR_W:0]   sum;

  // x/255 == (x + (x >> 8) + 1) >> 8 for every 16-bit product of two bytes
  assign product = value * brightness;
  assign sum     = {1'b0, product} + {9'd0, product[15:8]} + 17'd1;
  assign scaled  = sum[15:8];

endmodule

// ===== hw/rtl/wse_frame_seq.sv =====
// Frame sequencer: color latch, LED/byte/trailer counters and result register.
// Depends on wse_pkg for types, constants and the nibble encoder.
module wse_frame_seq #(
  parameter int MAX_LEDS = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  wse_pkg::seq_ctrl_t            ctrl,
  input  logic [3*wse_pkg::COLOR_W-1:0] color_in,
  input  wse_pkg::frame_cfg_t           cfg,
  input  logic                          out_stall,
  output logic                          out_valid,
  output logic [7:0]                    spi_byte,
  output logic                          last_byte
);

  localparam int LIDX_W = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
  localparam int CNT_W  = ($clog2(MAX_LEDS + 1) > wse_pkg::LED_CNT_W) ?
                          $clog2(MAX_LEDS + 1) : wse_pkg::LED_CNT_W;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_PIXELS,
    PH_TRAILER
  } phase_t;

  phase_t                             phase, phase_next;
  logic [3*wse_pkg::COLOR_W-1:0]      scaled_color;
  logic [LIDX_W-1:0]                  led_index, led_index_next;
  logic [wse_pkg::BYTE_IDX_W-1:0]     byte_index, byte_index_next;
  logic [wse_pkg::TRAIL_W-1:0]        trailer_index, trailer_index_next;

  logic [CNT_W-1:0]                   count_ext;
  logic [CNT_W-1:0]                   eff_leds;
  logic                               led_done;
  logic                               trail_done;
  logic [wse_pkg::COLOR_W-1:0]        cur_color;
  logic                               res_valid;
  logic [7:0]                         res_byte;
  logic                               res_last;

  always_comb begin
    count_ext = CNT_W'(cfg.chain_len);
    eff_leds  = count_ext;
    if (count_ext == '0) begin
      eff_leds = CNT_W'(1);
    end else if (count_ext > CNT_W'(MAX_LEDS)) begin
      eff_leds = CNT_W'(MAX_LEDS);
    end
  end

  assign led_done   = (CNT_W'(led_index) + CNT_W'(1)) >= eff_leds;
  assign trail_done = ({1'b0, trailer_index} + 9'd1) >= {1'b0, cfg.trailer_bytes};

  always_comb begin
    case (byte_index[3:2])
      2'd0:    cur_color = scaled_color[23:16];
      2'd1:    cur_color = scaled_color[15:8];
      default: cur_color = scaled_color[7:0];
    endcase
  end

  always_comb begin
    phase_next         = phase;
    led_index_next     = led_index;
    byte_index_next    = byte_index;
    trailer_index_next = trailer_index;
    res_valid          = 1'b0;
    res_byte           = wse_pkg::encode_pair(cur_color, byte_index[1:0]);
    res_last           = 1'b0;
    if (ctrl.arm) begin
      phase_next         = PH_PIXELS;
      led_index_next     = '0;
      byte_index_next    = '0;
      trailer_index_next = '0;
    end else if (ctrl.fetch) begin
      case (phase)
        PH_PIXELS: begin
          res_valid = 1'b1;
          if (byte_index >= wse_pkg::LAST_BYTE_IDX) begin
            byte_index_next = '0;
            if (led_done) begin
              led_index_next = '0;
              if (cfg.trailer_bytes == '0) begin
                res_last   = 1'b1;
                phase_next = PH_IDLE;
              end else begin
                trailer_index_next = '0;
                phase_next         = PH_TRAILER;
              end
            end else begin
              led_index_next = led_index + LIDX_W'(1);
            end
          end else begin
            byte_index_next = byte_index + 4'd1;
          end
        end
        PH_TRAILER: begin
          res_valid = 1'b1;
          res_byte  = 8'h00;
          if (trail_done) begin
            res_last           = 1'b1;
            trailer_index_next = '0;
            phase_next         = PH_IDLE;
          end else begin
            trailer_index_next = trailer_index + 8'd1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      led_index     <= '0;
      byte_index    <= '0;
      trailer_index <= '0;
      scaled_color  <= '0;
      out_valid     <= 1'b0;
    end else begin
      phase         <= phase_next;
      led_index     <= led_index_next;
      byte_index    <= byte_index_next;
      trailer_index <= trailer_index_next;
      if (ctrl.arm) begin
        scaled_color <= color_in;
      end
      // Load a fresh result, or drop the held one once it is taken
      if (res_valid) begin
        out_valid <= 1'b1;
        spi_byte  <= res_byte;
        last_byte <= res_last;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== hw/rtl/ws2812_spi_frame_encoder.sv =====
// Top level of the WS2812 SPI frame encoder: config registers, handshake, checks.
// Depends on wse_pkg, wse_color_scale and wse_frame_seq.
//
// Takes one item per clock. A set-color item (command 0) scales red, green
// and blue by brightness/255, latches them and arms a frame; it returns
// nothing. Each fetch item (command 1) returns the next SPI byte of the armed
// frame in the cycle after it is taken: chain_len LEDs of green, red, blue, each
// color byte sent MSB first as four bytes with two LED bits per byte (nibble
// 8 for a 0 bit, E for a 1 bit), then trailer_bytes zero bytes, with last_byte
// set on the final byte. A fetch while no frame is armed returns nothing.
// The single result register sets the pace: in_stall rises only while that
// register holds a result and out_stall is high, so with a free-running
// consumer one byte leaves every cycle. chain_len 0 counts as one LED and is
// capped at MAX_LEDS; chain_len and trailer_bytes are read live during a
// frame, brightness only at the next set color. Configuration writes are
// always taken (cfg_ready tied high); writes to an unused index are ignored.
module ws2812_spi_frame_encoder #(
  parameter int MAX_LEDS = 1024
) (
  input  logic                              clk,
  input  logic                              rst,
  // Item channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              command,
  input  logic [wse_pkg::COLOR_W-1:0]       red,
  input  logic [wse_pkg::COLOR_W-1:0]       green,
  input  logic [wse_pkg::COLOR_W-1:0]       blue,
  // Result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [7:0]                        spi_byte,
  output logic                              last_byte,
  // Configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [wse_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [wse_pkg::CFG_DAT_W-1:0]     cfg_data
);

  logic [wse_pkg::COLOR_W-1:0]   brightness;
  logic [wse_pkg::LED_CNT_W-1:0] chain_len;
  logic [wse_pkg::TRAIL_W-1:0]   trailer_bytes;

  logic                          take;
  wse_pkg::seq_ctrl_t            ctrl;
  wse_pkg::frame_cfg_t           frame_cfg;
  logic [wse_pkg::COLOR_W-1:0]   red_s, green_s, blue_s;

  // Hold off new items only while a finished byte waits on a stalled consumer
  assign in_stall  = out_valid & out_stall;
  assign take      = in_valid & ~in_stall;
  assign ctrl.arm   = take & (command == wse_pkg::CMD_SET);
  assign ctrl.fetch = take & (command == wse_pkg::CMD_FETCH);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      brightness    <= wse_pkg::BRIGHTNESS_RST;
      chain_len     <= wse_pkg::LED_COUNT_RST;
      trailer_bytes <= wse_pkg::TRAILER_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        wse_pkg::CFG_BRIGHTNESS: brightness    <= cfg_data[7:0];
        wse_pkg::CFG_LED_COUNT:  chain_len     <= cfg_data;
        wse_pkg::CFG_TRAILER:    trailer_bytes <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign frame_cfg.chain_len     = chain_len;
  assign frame_cfg.trailer_bytes = trailer_bytes;

  // One scaler per color, feeding the color latch directly
  wse_color_scale u_scale_r (.value(red),   .brightness(brightness), .scaled(red_s));
  wse_color_scale u_scale_g (.value(green), .brightness(brightness), .scaled(green_s));
  wse_color_scale u_scale_b (.value(blue),  .brightness(brightness), .scaled(blue_s));

  wse_frame_seq #(
    .MAX_LEDS (MAX_LEDS)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .color_in  ({green_s, red_s, blue_s}),
    .cfg       (frame_cfg),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .spi_byte  (spi_byte),
    .last_byte (last_byte)
  );

  // A set-color item never leaves a result behind
  a_set_no_result: assert property (@(posedge clk) disable iff (rst)
    ctrl.arm |=> !out_valid)
    else $error("set color produced a result");

  // A result that is held under stall keeps its byte and mark
  a_held_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(spi_byte) && $stable(last_byte)))
    else $error("held result changed");

  // Brightness write lands in the register
  a_cfg_bright: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready && cfg_index == wse_pkg::CFG_BRIGHTNESS)
      |=> (brightness == $past(cfg_data[7:0])))
    else $error("brightness write lost");

endmodule

// ===== bench/ws2812_spi_frame_encoder_checker.sv =====
`timescale 1ns / 1ps
// Frame checker for the WS2812 SPI frame encoder: follows every accepted item and
// register write, predicts each SPI byte and compares it. Depends on wse_pkg.
module ws2812_spi_frame_encoder_checker #(
  parameter int MAX_LEDS = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic                          command,
  input  logic [wse_pkg::COLOR_W-1:0]   red,
  input  logic [wse_pkg::COLOR_W-1:0]   green,
  input  logic [wse_pkg::COLOR_W-1:0]   blue,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [7:0]                    spi_byte,
  input  logic                          last_byte,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [wse_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [wse_pkg::CFG_DAT_W-1:0] cfg_data,
  output int                            mismatch_count,
  output int                            bytes_outstanding
);
  import wse_pkg::*;

  typedef enum logic [1:0] {PH_IDLE, PH_PIXELS, PH_TRAILER} frame_phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } spi_result_t;

  logic [COLOR_W-1:0]    brightness_q;
  logic [LED_CNT_W-1:0]  chain_len_q;
  logic [TRAIL_W-1:0]    trailer_q;
  logic [COLOR_W-1:0]    grn_q, red_q, blu_q;
  int unsigned           led_pos;
  logic [BYTE_IDX_W-1:0] byte_pos;
  logic [TRAIL_W-1:0]    trail_pos;
  frame_phase_t          phase;
  spi_result_t           expected_bytes[$];

  initial begin
    mismatch_count = 0;
    bytes_outstanding = 0;
  end

  function automatic logic [7:0] scale(input logic [COLOR_W-1:0] v);
    return 8'((int'(v) * int'(brightness_q)) / 255);
  endfunction

  // Two LED bits, MSB first, one nibble each
  function automatic logic [7:0] wire_byte(input logic [7:0] c, input logic [1:0] slot);
    logic [7:0] shifted;
    shifted = c >> (6 - 2 * int'(slot));
    return {(shifted[1] ? NIB_ONE : NIB_ZERO), (shifted[0] ? NIB_ONE : NIB_ZERO)};
  endfunction

  function automatic int unsigned leds_per_frame();
    int unsigned n;
    n = chain_len_q;
    if (n == 0) n = 1;
    if (n > MAX_LEDS) n = MAX_LEDS;
    return n;
  endfunction

  task automatic arm_frame();
    grn_q = scale(green);
    red_q = scale(red);
    blu_q = scale(blue);
    led_pos = 0;
    byte_pos = '0;
    trail_pos = '0;
    phase = PH_PIXELS;
  endtask

  task automatic fetch_byte();
    spi_result_t r;
    logic [7:0] c;
    r = '0;
    if (phase == PH_PIXELS) begin
      case (byte_pos[3:2])
        2'd0:    c = grn_q;
        2'd1:    c = red_q;
        default: c = blu_q;
      endcase
      r.data = wire_byte(c, byte_pos[1:0]);
      if (byte_pos >= LAST_BYTE_IDX) begin
        byte_pos = '0;
        if (led_pos + 1 >= leds_per_frame()) begin
          led_pos = 0;
          trail_pos = '0;
          if (trailer_q == 0) begin
            r.last = 1'b1;
            phase = PH_IDLE;
          end else begin
            phase = PH_TRAILER;
          end
        end else begin
          led_pos++;
        end
      end else begin
        byte_pos++;
      end
      expected_bytes.push_back(r);
    end else if (phase == PH_TRAILER) begin
      if (int'(trail_pos) + 1 >= int'(trailer_q)) begin
        r.last = 1'b1;
        trail_pos = '0;
        phase = PH_IDLE;
      end else begin
        trail_pos++;
      end
      expected_bytes.push_back(r);
    end
  endtask

  task automatic compare_byte();
    spi_result_t e;
    if (expected_bytes.size() == 0) begin
      mismatch_count++;
      $display("%0t ns: spi_byte expected none, actual %02h (last_byte %0b)",
               $time, spi_byte, last_byte);
    end else begin
      e = expected_bytes.pop_front();
      if (spi_byte !== e.data) begin
        mismatch_count++;
        $display("%0t ns: spi_byte expected %02h, actual %02h", $time, e.data, spi_byte);
      end
      if (last_byte !== e.last) begin
        mismatch_count++;
        $display("%0t ns: last_byte expected %0b, actual %0b", $time, e.last, last_byte);
      end
    end
  endtask

  // Results leave before new items enter, so an item taken at this edge
  // can never pair with a byte leaving at the same edge.
  always @(posedge clk) begin
    if (rst) begin
      brightness_q = BRIGHTNESS_RST;
      chain_len_q = LED_COUNT_RST;
      trailer_q = TRAILER_RST;
      grn_q = '0;
      red_q = '0;
      blu_q = '0;
      led_pos = 0;
      byte_pos = '0;
      trail_pos = '0;
      phase = PH_IDLE;
      expected_bytes.delete();
    end else begin
      if (out_valid && !out_stall) compare_byte();
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_BRIGHTNESS: brightness_q = cfg_data[COLOR_W-1:0];
          CFG_LED_COUNT:  chain_len_q = cfg_data[LED_CNT_W-1:0];
          CFG_TRAILER:    trailer_q = cfg_data[TRAIL_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (command == CMD_SET) arm_frame();
        else fetch_byte();
      end
    end
    bytes_outstanding <= expected_bytes.size();
  end

endmodule

// ===== bench/ws2812_spi_frame_encoder_tb.sv =====
`timescale 1ns / 1ps
// Top of the WS2812 SPI frame encoder bench: clock, reset, item and register stimulus
// and the verdict. Depends on wse_pkg, the encoder RTL and the frame checker.
module ws2812_spi_frame_encoder_tb;
  import wse_pkg::*;

  localparam int MAX_LEDS      = 1024;
  localparam int BYTES_PER_LED = 12;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;  // unused index, writes ignored

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 command = CMD_FETCH;
  logic [COLOR_W-1:0]   red = '0;
  logic [COLOR_W-1:0]   green = '0;
  logic [COLOR_W-1:0]   blue = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [7:0]           spi_byte;
  logic                 last_byte;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_BRIGHTNESS;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  int mismatch_count;
  int bytes_outstanding;
  int cycle_count = 0;

  // Idling odds in percent; the main sequence moves through three settings.
  int send_idle_pct = 7;
  int recv_stall_pct = 86;

  // Register values as last written, used only to size the frames we send.
  logic [LED_CNT_W-1:0] cur_leds = LED_COUNT_RST;
  logic [TRAIL_W-1:0]   cur_trail = TRAILER_RST;

  ws2812_spi_frame_encoder #(.MAX_LEDS(MAX_LEDS)) dut (.*);

  ws2812_spi_frame_encoder_checker #(.MAX_LEDS(MAX_LEDS)) frame_check (.*);

  always #5 clk = ~clk;

  // Receiver: roll a new stall decision every falling edge.
  always @(negedge clk) out_stall <= ($urandom_range(0, 99) < recv_stall_pct);

  // Watchdog: a lost byte or a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Present one item, idling at random first, and hold it until taken.
  // Valid stays high on return so back-to-back items need no gap.
  task automatic send_item(input logic cmd, input logic [COLOR_W-1:0] r,
                           input logic [COLOR_W-1:0] g, input logic [COLOR_W-1:0] b);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    red <= r;
    green <= g;
    blue <= b;
    do @(posedge clk); while (in_stall);
  endtask

  // Fetch items carry random colors; the block must ignore them.
  task automatic fetch(input int n);
    repeat (n) send_item(CMD_FETCH, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // Drop valid, wait out every expected byte, then let the block settle in
  // case the last item was one that returns nothing.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (bytes_outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_LED_COUNT) cur_leds = data[LED_CNT_W-1:0];
    else if (idx == CFG_TRAILER) cur_trail = data[TRAIL_W-1:0];
  endtask

  task automatic configure(input logic [COLOR_W-1:0] bright, input logic [LED_CNT_W-1:0] leds,
                           input logic [TRAIL_W-1:0] trail);
    settle();
    write_reg(CFG_BRIGHTNESS, CFG_DAT_W'(bright));
    write_reg(CFG_LED_COUNT, CFG_DAT_W'(leds));
    write_reg(CFG_TRAILER, CFG_DAT_W'(trail));
  endtask

  function automatic int frame_bytes();
    int n;
    n = cur_leds;
    if (n == 0) n = 1;
    if (n > MAX_LEDS) n = MAX_LEDS;
    return n * BYTES_PER_LED + cur_trail;
  endfunction

  // Mostly complete frames with random colors; some frames are cut short by
  // the next set color, some run past the end into idle fetches.
  // Hand back the number of items actually sent.
  task automatic random_frames(input int budget, output int sent);
    int roll;
    int n;
    sent = 0;
    while (sent < budget) begin
      roll = $urandom_range(0, 99);
      if (roll < 6) begin
        fetch(1);
        sent += 1;
      end else begin
        if (roll >= 94) settle();
        send_item(CMD_SET, 8'($urandom), 8'($urandom), 8'($urandom));
        if (roll < 20) n = $urandom_range(0, frame_bytes() - 1);
        else n = frame_bytes() + $urandom_range(0, 2);
        fetch(n);
        sent += n + 1;
      end
    end
  endtask

  // Favor the edges: full and zero brightness, one LED, no trailer, long trailer.
  task automatic random_config();
    logic [COLOR_W-1:0]   bright;
    logic [LED_CNT_W-1:0] leds;
    logic [TRAIL_W-1:0]   trail;
    int pick;
    pick = $urandom_range(0, 3);
    bright = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 : 8'($urandom);
    pick = $urandom_range(0, 9);
    leds = (pick == 0) ? 11'd0 : (pick == 1) ? 11'd1 : 11'($urandom_range(2, 4));
    pick = $urandom_range(0, 19);
    if (pick < 4) trail = 8'd0;
    else if (pick == 4) trail = 8'd255;
    else if (pick == 5) trail = 8'd1;
    else trail = 8'($urandom_range(2, 10));
    configure(bright, leds, trail);
    if ($urandom_range(0, 7) == 0) write_reg(CFG_SPARE, CFG_DAT_W'($urandom));
  endtask

  task automatic random_phase(input int budget);
    int sent;
    int used;
    sent = 0;
    while (sent < budget) begin
      random_config();
      random_frames(70, used);
      sent += used;
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Fetch with no frame armed: nothing comes back.
    fetch(1);

    // A chain length of zero acts as one LED, no trailer: the last pixel byte
    // ends the frame. Colors cover every nibble pair; the spare index is ignored.
    configure(8'd255, 11'd0, 8'd0);
    write_reg(CFG_SPARE, 11'h7FF);
    send_item(CMD_SET, 8'hFF, 8'h00, 8'hA5);
    fetch(12);

    // Restart a frame with a second set color, then shrink the frame while
    // it runs: the current LED becomes the last and the trailer vanishes.
    // The new brightness must not touch the colors already latched.
    configure(8'd255, 11'd2, 8'd2);
    send_item(CMD_SET, 8'h80, 8'h01, 8'hFE);
    fetch(2);
    send_item(CMD_SET, 8'hFE, 8'h80, 8'h01);
    fetch(1);
    configure(8'd0, 11'd1, 8'd0);
    fetch(11);

    // Slow receiver.
    random_phase(350);

    // Slow sender.
    settle();
    send_idle_pct = 86;
    recv_stall_pct = 7;
    random_phase(350);

    // Full rate both ways.
    settle();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    random_phase(370);

    // A chain length past MAX_LEDS saturates: the frame runs on over
    // several LEDs without ending early.
    configure(8'($urandom), 11'd2047, 8'd255);
    send_item(CMD_SET, 8'($urandom), 8'($urandom), 8'($urandom));
    fetch(60);

    settle();
    if (mismatch_count == 0 && bytes_outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
